// ----- design/device_address_table_mark_sweep_assert.svh -----
// assertion helpers for the device address table
`ifndef DEVICE_ADDRESS_TABLE_MARK_SWEEP_ASSERT_SVH
`define DEVICE_ADDRESS_TABLE_MARK_SWEEP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define DATMS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define DATMS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/datms_pkg.sv -----
`timescale 1ns / 1ps

package datms_pkg;

	// table sizing
	localparam int TABLE_DEPTH_DEF = 32;
	localparam int KEY_BYTES       = 15;
	localparam int KEY_MAX_BYTES   = 15;
	localparam int KEY_W           = 8 * KEY_MAX_BYTES;
	localparam int MAX_OUT         = 32;
	localparam int CNT_W           = 6;

	// mark values
	localparam logic MARK_SET   = 1'b1;
	localparam logic MARK_CLEAR = 1'b0;

	// operation codes
	localparam logic [2:0] OP_ADD       = 3'd0;
	localparam logic [2:0] OP_FIND      = 3'd1;
	localparam logic [2:0] OP_FIND_MARK = 3'd2;
	localparam logic [2:0] OP_DELETE    = 3'd3;
	localparam logic [2:0] OP_CLEAR_ALL = 3'd4;
	localparam logic [2:0] OP_SWEEP     = 3'd5;
	localparam logic [2:0] OP_LIST      = 3'd6;
	localparam logic [2:0] OP_UNUSED    = 3'd7;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// one stored table entry
	typedef struct packed {
		logic [63:0] key_low;
		logic [55:0] key_high;
		logic [15:0] etype;
	} entry_t;

	// one result word
	typedef struct packed {
		logic [1:0]       status;
		logic [15:0]      found_type;
		logic [63:0]      key_low;
		logic [55:0]      key_high;
		logic [CNT_W-1:0] count;
		logic             last;
	} result_t;

	// key ends at its first zero byte; later bytes and bytes past KEY_BYTES are zero
	function automatic logic [KEY_W-1:0] normalize_key(input logic [63:0] lo,
		input logic [55:0] hi);
		logic [KEY_W-1:0] k;
		logic             ended;
		k     = {hi, lo};
		ended = 1'b0;
		for (int i = 0; i < KEY_MAX_BYTES; i++) begin
			if (i >= KEY_BYTES || k[8*i +: 8] == 8'd0) begin
				ended = 1'b1;
			end
			if (ended) begin
				k[8*i +: 8] = 8'd0;
			end
		end
		return k;
	endfunction

endpackage

// ----- design/device_address_table_mark_sweep.sv -----
`timescale 1ns / 1ps
// Device address table with mark and sweep.
// Input channel (in_valid / in_stall): one word per operation with operation,
// key_low, key_high, type_value and max_rows. Output channel (out_valid /
// out_stall): result words with status, found_type, out_key_low, out_key_high,
// listed_count and last; last is high on the final word of each operation.
// Config channel (cfg_valid / cfg_ready): cfg_data sets the type reported on
// a miss; cfg_ready is always high, write only while the block is idle.
// Every operation but clear all and the unused code walks the whole table
// through the entry memory, one slot read per cycle while the output register
// can take a word, and a new input word is taken only after the last word of
// the item is loaded and the sequencer is back in idle; clear all and the unused
// code skip the walk and go straight to the closing word. The slot scan and
// its single read port bound the walk. Sweep and list emit one word per matching
// slot as the walk goes, holding one word back so the final one can carry last.
// A stall on the output freezes the walk until the output register drains;
// no word is lost or repeated. Input is stalled while an item is in work.
// Reset empties the table (valid and mark bits cleared at once, no sweep of
// the memory) and sets the miss type to 16'hFFFF.
`include "device_address_table_mark_sweep_assert.svh"

module device_address_table_mark_sweep #(
	parameter int TABLE_DEPTH = datms_pkg::TABLE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// input words
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  operation,
	input  logic [63:0]                 key_low,
	input  logic [55:0]                 key_high,
	input  logic [15:0]                 type_value,
	input  logic [datms_pkg::CNT_W-1:0] max_rows,
	// result words
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [15:0]                 found_type,
	output logic [63:0]                 out_key_low,
	output logic [55:0]                 out_key_high,
	output logic [datms_pkg::CNT_W-1:0] listed_count,
	output logic                        last,
	// config write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [15:0]                 cfg_data
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [datms_pkg::CNT_W-1:0] CNT_MAX = datms_pkg::CNT_W'(datms_pkg::MAX_OUT);
	localparam logic [datms_pkg::CNT_W-1:0] CNT_ONE = datms_pkg::CNT_W'(1);

	// sequencer state codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	// control state
	logic [1:0]                  state_q;
	logic                        issue_q;
	logic [IDX_W-1:0]            scan_idx_q;
	logic                        valid_s1;
	logic [TABLE_DEPTH-1:0]      slot_valid_q;
	logic [TABLE_DEPTH-1:0]      slot_mark_q;
	logic [datms_pkg::CNT_W-1:0] n_q;
	logic                        hit_q;
	logic                        free_found_q;
	logic                        pend_valid_q;
	logic                        out_valid_q;
	logic [15:0]                 nft_q;

	// payload state
	logic [2:0]                  op_q;
	logic [63:0]                 key_lo_q;
	logic [55:0]                 key_hi_q;
	logic [15:0]                 tv_q;
	logic [datms_pkg::CNT_W-1:0] rows_q;
	logic [IDX_W-1:0]            idx_s1;
	datms_pkg::entry_t           rd_s1;
	logic [IDX_W-1:0]            hit_idx_q;
	logic [15:0]                 hit_type_q;
	logic [IDX_W-1:0]            free_idx_q;
	datms_pkg::result_t          pend_q;
	datms_pkg::result_t          out_q;

	// entry memory
	datms_pkg::entry_t           mem_q [TABLE_DEPTH];

	// combinational control
	logic                        in_acc;
	logic                        adv;
	logic                        s1_go;
	logic                        s1_v;
	logic                        s1_m;
	logic                        s1_hit;
	logic                        s1_free;
	logic                        s1_clr;
	logic                        s1_emit;
	logic                        fin;
	logic                        out_load;
	datms_pkg::result_t          emit_res;
	datms_pkg::result_t          fin_res;
	datms_pkg::result_t          out_next;
	logic                        mem_re;
	logic                        mem_we;
	logic [IDX_W-1:0]            mem_waddr;
	datms_pkg::entry_t           mem_wdata;
	logic [datms_pkg::KEY_W-1:0] norm_key;
	logic [datms_pkg::CNT_W-1:0] rows_norm;
	logic                        scan_op;

	// handshake and input normalization
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign norm_key  = datms_pkg::normalize_key(key_low, key_high);
	assign rows_norm = (max_rows == '0 || max_rows > CNT_MAX) ? CNT_MAX : max_rows;
	assign scan_op   = (operation != datms_pkg::OP_CLEAR_ALL)
		&& (operation != datms_pkg::OP_UNUSED);

	// walk advances only when the output register can take a word
	assign adv    = !out_valid_q || !out_stall;
	assign mem_re = (state_q == S_SCAN) && issue_q && adv;
	assign s1_go  = (state_q == S_SCAN) && valid_s1 && adv;
	assign s1_v   = slot_valid_q[idx_s1];
	assign s1_m   = slot_mark_q[idx_s1];

	// per-slot decisions on the registered read word
	always_comb begin
		s1_hit  = s1_go && s1_v && rd_s1.key_low == key_lo_q && rd_s1.key_high == key_hi_q;
		s1_free = s1_go && !s1_v && !free_found_q;
		s1_clr  = s1_go && s1_v && op_q == datms_pkg::OP_SWEEP
			&& s1_m == datms_pkg::MARK_SET;
		s1_emit = s1_go && s1_v && (
			(op_q == datms_pkg::OP_SWEEP && s1_m == datms_pkg::MARK_CLEAR
				&& n_q < CNT_MAX) ||
			(op_q == datms_pkg::OP_LIST && rd_s1.etype == tv_q && n_q < rows_q));
		emit_res.status     = datms_pkg::ST_OK;
		emit_res.found_type = rd_s1.etype;
		emit_res.key_low    = rd_s1.key_low;
		emit_res.key_high   = rd_s1.key_high;
		emit_res.count      = n_q + CNT_ONE;
		emit_res.last       = 1'b0;
	end

	// closing word of an operation
	always_comb begin
		fin_res.status     = datms_pkg::ST_EMPTY;
		fin_res.found_type = nft_q;
		fin_res.key_low    = '0;
		fin_res.key_high   = '0;
		fin_res.count      = '0;
		fin_res.last       = 1'b1;
		case (op_q) inside
			datms_pkg::OP_ADD: begin
				fin_res.key_low  = key_lo_q;
				fin_res.key_high = key_hi_q;
				if (hit_q || free_found_q) begin
					fin_res.status     = datms_pkg::ST_OK;
					fin_res.found_type = tv_q;
				end else begin
					fin_res.status = datms_pkg::ST_FULL;
				end
			end
			datms_pkg::OP_FIND, datms_pkg::OP_FIND_MARK, datms_pkg::OP_DELETE: begin
				fin_res.key_low  = key_lo_q;
				fin_res.key_high = key_hi_q;
				if (hit_q) begin
					fin_res.status     = datms_pkg::ST_OK;
					fin_res.found_type = hit_type_q;
				end else begin
					fin_res.status = datms_pkg::ST_NOT_FOUND;
				end
			end
			datms_pkg::OP_CLEAR_ALL: begin
				fin_res.status = datms_pkg::ST_OK;
			end
			default: begin
				if (pend_valid_q) begin
					fin_res      = pend_q;
					fin_res.last = 1'b1;
				end
			end
		endcase
	end

	// output register load and memory write
	always_comb begin
		fin      = (state_q == S_FIN) && adv;
		out_load = fin || (s1_emit && pend_valid_q);
		out_next = fin ? fin_res : pend_q;
		mem_we   = fin && op_q == datms_pkg::OP_ADD && (hit_q || free_found_q);
		mem_waddr          = hit_q ? hit_idx_q : free_idx_q;
		mem_wdata.key_low  = key_lo_q;
		mem_wdata.key_high = key_hi_q;
		mem_wdata.etype    = tv_q;
	end

	// entry memory, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_s1 <= mem_q[scan_idx_q];
		end
	end

	// sequencer and table flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			issue_q      <= 1'b0;
			scan_idx_q   <= '0;
			valid_s1     <= 1'b0;
			slot_valid_q <= '0;
			slot_mark_q  <= '0;
			n_q          <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			nft_q        <= 16'hFFFF;
		end else begin
			if (cfg_valid && cfg_ready) begin
				nft_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						n_q          <= '0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						pend_valid_q <= 1'b0;
						scan_idx_q   <= '0;
						if (scan_op) begin
							issue_q <= 1'b1;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (adv) begin
						valid_s1 <= mem_re;
						if (issue_q) begin
							scan_idx_q <= scan_idx_q + IDX_W'(1);
							if (scan_idx_q == LAST_IDX) begin
								issue_q <= 1'b0;
							end
						end
					end
					if (!issue_q && !valid_s1) begin
						state_q <= S_FIN;
					end
					if (s1_hit) begin
						hit_q <= 1'b1;
					end
					if (s1_free) begin
						free_found_q <= 1'b1;
					end
					if (s1_clr) begin
						slot_mark_q[idx_s1] <= datms_pkg::MARK_CLEAR;
					end
					if (s1_emit) begin
						n_q          <= n_q + CNT_ONE;
						pend_valid_q <= 1'b1;
					end
				end
				S_FIN: begin
					if (fin) begin
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
						case (op_q)
							datms_pkg::OP_ADD: begin
								if (!hit_q && free_found_q) begin
									slot_valid_q[free_idx_q] <= 1'b1;
									slot_mark_q[free_idx_q]  <= datms_pkg::MARK_CLEAR;
								end
							end
							datms_pkg::OP_FIND_MARK: begin
								if (hit_q) begin
									slot_mark_q[hit_idx_q] <= datms_pkg::MARK_SET;
								end
							end
							datms_pkg::OP_DELETE: begin
								if (hit_q) begin
									slot_valid_q[hit_idx_q] <= 1'b0;
									slot_mark_q[hit_idx_q]  <= datms_pkg::MARK_CLEAR;
								end
							end
							datms_pkg::OP_CLEAR_ALL: begin
								slot_valid_q <= '0;
								slot_mark_q  <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q     <= operation;
			key_lo_q <= norm_key[63:0];
			key_hi_q <= norm_key[datms_pkg::KEY_W-1:64];
			tv_q     <= type_value;
			rows_q   <= rows_norm;
		end
		if (mem_re) begin
			idx_s1 <= scan_idx_q;
		end
		if (s1_hit) begin
			hit_idx_q  <= idx_s1;
			hit_type_q <= rd_s1.etype;
		end
		if (s1_free) begin
			free_idx_q <= idx_s1;
		end
		if (s1_emit) begin
			pend_q <= emit_res;
		end
		if (out_load) begin
			out_q <= out_next;
		end
	end

	// output ports
	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign found_type   = out_q.found_type;
	assign out_key_low  = out_q.key_low;
	assign out_key_high = out_q.key_high;
	assign listed_count = out_q.count;
	assign last         = out_q.last;

	// checks
	`DATMS_ASSERT_NOW(a_pend_walk_only, clk, arst_n, pend_valid_q, (op_q == datms_pkg::OP_SWEEP || op_q == datms_pkg::OP_LIST), "held word outside a walk")
	`DATMS_ASSERT_NOW(a_count_cap, clk, arst_n, state_q == S_SCAN, n_q <= CNT_MAX, "emit count past limit")
	`DATMS_ASSERT_NOW(a_rw_exclusive, clk, arst_n, mem_we, !mem_re, "memory read and write together")
	`DATMS_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_acc, in_stall, "input not stalled after accept")
	`DATMS_ASSERT_NEXT(a_fin_idle, clk, arst_n, fin, (state_q == S_IDLE && !pend_valid_q && out_valid_q), "finish did not close the item")

endmodule
